// File: sv/ple_pkg.sv
package ple_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = 5;
    localparam int POS_W    = 5;
    localparam int FUNC_W   = 3;
    localparam int DATA_W   = 32;
    localparam int STAT_W   = 2;

    localparam logic [FUNC_W-1:0] FN_ADD_FRONT = 3'd0;
    localparam logic [FUNC_W-1:0] FN_ADD_BACK  = 3'd1;
    localparam logic [FUNC_W-1:0] FN_INSERT    = 3'd2;
    localparam logic [FUNC_W-1:0] FN_DEL_FRONT = 3'd3;
    localparam logic [FUNC_W-1:0] FN_DEL_BACK  = 3'd4;
    localparam logic [FUNC_W-1:0] FN_DEL_POS   = 3'd5;

    localparam logic [STAT_W-1:0] ST_DONE    = 2'd0;
    localparam logic [STAT_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL    = 2'd2;

    localparam logic [1:0] OP_HOLD = 2'd0;
    localparam logic [1:0] OP_INS  = 2'd1;
    localparam logic [1:0] OP_DEL  = 2'd2;
    localparam logic [1:0] OP_ROT  = 2'd3;

    typedef struct packed {
        logic [1:0]        op;
        logic [IDX_W-1:0]  idx;
        logic [DATA_W-1:0] value;
    } ple_cell_ctl_t;

endpackage

// File: sv/ple_cmd_if.sv
interface ple_cmd_if
    import ple_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic [POS_W-1:0]         position;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output func, output position, output value, input ready);
    modport sink   (input valid, input func, input position, input value, output ready);
endinterface

// File: sv/ple_res_if.sv
interface ple_res_if
    import ple_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic [CNT_W-1:0]         count;
    logic                     has_element;
    logic [CNT_W-1:0]         element_index;
    logic signed [DATA_W-1:0] element_value;
    logic                     last;

    modport source (output valid, output status, output count, output has_element,
                    output element_index, output element_value, output last,
                    input ready);
    modport sink   (input valid, input status, input count, input has_element,
                    input element_index, input element_value, input last,
                    output ready);
endinterface

// File: sv/ple_cell.sv
module ple_cell
    import ple_pkg::*;
(
    input  logic                  clk,
    input  logic [IDX_W-1:0]      cell_idx,
    input  ple_cell_ctl_t         ctl,
    input  logic [DATA_W-1:0]     left_data,
    input  logic [DATA_W-1:0]     right_data,
    output logic [DATA_W-1:0]     data
);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        unique case (ctl.op)
            OP_HOLD:
            begin
                data_next = data_reg;
            end
            OP_INS:
            begin
                if (cell_idx > ctl.idx)
                begin
                    data_next = left_data;
                end
                else if (cell_idx == ctl.idx)
                begin
                    data_next = ctl.value;
                end
            end
            OP_DEL:
            begin
                if (cell_idx >= ctl.idx)
                begin
                    data_next = right_data;
                end
            end
            OP_ROT:
            begin
                data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

// File: sv/positional_list_engine.sv
// Ordered list of up to CAPACITY signed 32-bit values held in a ring of cells, one value
// per cell. A command is taken only when the block is idle; it is applied to all cells in
// the cycle it is accepted (each cell shifts from its neighbor or loads the new value), then
// the list streams from the front cell while the ring rotates one place per step. The ring
// makes a full turn of CAPACITY steps so the order is restored; the steps that show an
// element wait while the result side holds ready low. An empty list gives one result.
// Rejected commands leave the list unchanged and still stream it with the error status on
// every result.
module positional_list_engine
    import ple_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    ple_cmd_if.sink   cmd,
    ple_res_if.source res
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_OUT  = 1'b1;

    logic              state_reg;
    logic              state_next;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic [IDX_W-1:0]  k_reg;
    logic [IDX_W-1:0]  k_next;
    logic [STAT_W-1:0] status_reg;
    logic [STAT_W-1:0] status_next;

    logic              acc;
    logic              cmd_ok;
    logic              cmd_ins;
    logic [STAT_W-1:0] cmd_status;
    logic [IDX_W-1:0]  cmd_idx;
    logic [POS_W-1:0]  pos_m1;
    logic [CNT_W:0]    cnt_p1;
    logic [CNT_W-1:0]  cnt_m1;
    logic [CNT_W-1:0]  k_ext;
    logic              in_list;
    logic              advance;
    ple_cell_ctl_t     ctl;
    logic [DATA_W-1:0] cell_data [CAPACITY];

    assign acc     = cmd.valid && cmd.ready;
    assign pos_m1  = cmd.position - POS_W'(1);
    assign cnt_p1  = {1'b0, count_reg} + (CNT_W+1)'(1);
    assign cnt_m1  = count_reg - CNT_W'(1);
    assign k_ext   = CNT_W'(k_reg);
    assign in_list = k_ext < count_reg;

    // command decode
    always_comb
    begin
        cmd_ok     = 1'b0;
        cmd_ins    = 1'b0;
        cmd_status = ST_INVALID;
        cmd_idx    = '0;
        unique case (cmd.func)
            FN_ADD_FRONT, FN_ADD_BACK, FN_INSERT:
            begin
                cmd_ins = 1'b1;
                if (count_reg >= CNT_W'(CAPACITY))
                begin
                    cmd_status = ST_FULL;
                end
                else if (cmd.func == FN_ADD_FRONT)
                begin
                    cmd_ok = 1'b1;
                end
                else if (cmd.func == FN_ADD_BACK)
                begin
                    cmd_ok  = 1'b1;
                    cmd_idx = count_reg[IDX_W-1:0];
                end
                else if (cmd.position != '0 && {1'b0, cmd.position} <= cnt_p1)
                begin
                    cmd_ok  = 1'b1;
                    cmd_idx = pos_m1[IDX_W-1:0];
                end
            end
            FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_POS:
            begin
                if (count_reg == '0)
                begin
                    cmd_ok = 1'b0;
                end
                else if (cmd.func == FN_DEL_FRONT)
                begin
                    cmd_ok = 1'b1;
                end
                else if (cmd.func == FN_DEL_BACK)
                begin
                    cmd_ok  = 1'b1;
                    cmd_idx = cnt_m1[IDX_W-1:0];
                end
                else if (cmd.position != '0 && cmd.position <= count_reg)
                begin
                    cmd_ok  = 1'b1;
                    cmd_idx = pos_m1[IDX_W-1:0];
                end
            end
            default:
            begin
                cmd_ok = 1'b0;
            end
        endcase
        if (cmd_ok)
        begin
            cmd_status = ST_DONE;
        end
    end

    assign advance = in_list ? res.ready : 1'b1;

    // sequencer
    always_comb
    begin
        state_next  = state_reg;
        count_next  = count_reg;
        k_next      = k_reg;
        status_next = status_reg;
        ctl.op      = OP_HOLD;
        ctl.idx     = cmd_idx;
        ctl.value   = cmd.value;
        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    state_next  = S_OUT;
                    status_next = cmd_status;
                    k_next      = '0;
                    if (cmd_ok)
                    begin
                        ctl.op     = cmd_ins ? OP_INS : OP_DEL;
                        count_next = cmd_ins ? count_reg + CNT_W'(1) : cnt_m1;
                    end
                end
            end
            S_OUT:
            begin
                if (count_reg == '0)
                begin
                    if (res.ready)
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (advance)
                begin
                    ctl.op = OP_ROT;
                    k_next = k_reg + IDX_W'(1);
                    if (k_reg == IDX_W'(CAPACITY - 1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            k_reg      <= '0;
            status_reg <= ST_DONE;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            k_reg      <= k_next;
            status_reg <= status_next;
        end
    end

    // ring of cells, front at index 0
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        ple_cell u_cell (
            .clk        (clk),
            .cell_idx   (IDX_W'(i)),
            .ctl        (ctl),
            .left_data  (cell_data[(i + CAPACITY - 1) % CAPACITY]),
            .right_data (cell_data[(i + 1) % CAPACITY]),
            .data       (cell_data[i])
        );
    end

    assign cmd.ready         = (state_reg == S_IDLE);
    assign res.valid         = (state_reg == S_OUT) &&
                               ((count_reg == '0) ? (k_reg == '0) : in_list);
    assign res.status        = status_reg;
    assign res.count         = count_reg;
    assign res.has_element   = (count_reg != '0);
    assign res.element_index = (count_reg == '0) ? '0 : k_ext + CNT_W'(1);
    assign res.element_value = (count_reg == '0) ? '0 : cell_data[0];
    assign res.last          = (count_reg == '0) || (k_ext == cnt_m1);

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(CAPACITY))
        else $error("list count above capacity");

    a_cmd_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
        acc |=> (state_reg == S_OUT) && (k_reg == '0))
        else $error("command did not start a result run");

    a_reject_keeps_count: assert property (@(posedge clk) disable iff (!rst_n)
        (acc && !cmd_ok) |=> (count_reg == $past(count_reg)))
        else $error("rejected command changed the list count");

    a_no_cmd_during_run: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid |-> !cmd.ready)
        else $error("command port open while results pending");

    a_empty_single: assert property (@(posedge clk) disable iff (!rst_n)
        (res.valid && res.ready && count_reg == '0) |=> (state_reg == S_IDLE))
        else $error("empty list gave more than one result");

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import ple_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED_6 = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNUSED_7 = 3'd7;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [CNT_W-1:0]  count;
        logic              has_element;
        logic [CNT_W-1:0]  element_index;
        logic [DATA_W-1:0] element_value;
        logic              last;
    } list_view_t;

    logic clk;
    logic rst_n;

    ple_cmd_if cmd_bus ();
    ple_res_if res_bus ();

    positional_list_engine dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_bus),
        .res   (res_bus)
    );

    logic [DATA_W-1:0] list_shadow[$];
    list_view_t        expected_views[$];
    int unsigned       mismatch_count     = 0;
    int unsigned       result_hold_cycles = 0;
    bit                steady_flow        = 1'b0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #2_400_000;
        $display("** positional_list_engine: FAILED **");
        $finish;
    end

    function automatic int unsigned idle_cycles();
        return steady_flow ? 0 : $urandom_range(0, 15);
    endfunction

    // update the shadow list and queue the streamed view it produces
    function automatic void apply_command(input logic [FUNC_W-1:0] f,
                                          input logic [POS_W-1:0]  p,
                                          input logic [DATA_W-1:0] v);
        logic [STAT_W-1:0] st;
        int unsigned       sz;
        list_view_t        view;
        st = ST_DONE;
        sz = list_shadow.size();
        case (f)
            FN_ADD_FRONT, FN_ADD_BACK, FN_INSERT:
            begin
                if (sz >= CAPACITY)
                    st = ST_FULL;
                else if (f == FN_ADD_FRONT)
                    list_shadow.push_front(v);
                else if (f == FN_ADD_BACK)
                    list_shadow.push_back(v);
                else if (p >= 1 && p <= sz + 1)
                    list_shadow.insert(int'(p) - 1, v);
                else
                    st = ST_INVALID;
            end
            FN_DEL_FRONT, FN_DEL_BACK, FN_DEL_POS:
            begin
                if (sz == 0)
                    st = ST_INVALID;
                else if (f == FN_DEL_FRONT)
                    void'(list_shadow.pop_front());
                else if (f == FN_DEL_BACK)
                    void'(list_shadow.pop_back());
                else if (p >= 1 && p <= sz)
                    list_shadow.delete(int'(p) - 1);
                else
                    st = ST_INVALID;
            end
            default:
            begin
                st = ST_INVALID;
            end
        endcase
        sz = list_shadow.size();
        if (sz == 0)
        begin
            view = '{status: st, count: '0, has_element: 1'b0, element_index: '0,
                     element_value: '0, last: 1'b1};
            expected_views.push_back(view);
        end
        for (int k = 0; k < sz; k++)
        begin
            view.status        = st;
            view.count         = CNT_W'(sz);
            view.has_element   = 1'b1;
            view.element_index = CNT_W'(k + 1);
            view.element_value = list_shadow[k];
            view.last          = (k + 1 == sz);
            expected_views.push_back(view);
        end
    endfunction

    task automatic send_command(input logic [FUNC_W-1:0] f,
                                input logic [POS_W-1:0]  p,
                                input logic [DATA_W-1:0] v);
        int unsigned gap;
        gap = idle_cycles();
        if (gap != 0)
        begin
            cmd_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_bus.valid    <= 1'b1;
        cmd_bus.func     <= f;
        cmd_bus.position <= p;
        cmd_bus.value    <= v;
        @(posedge clk);
        while (cmd_bus.ready !== 1'b1)
            @(posedge clk);
        apply_command(f, p, v);
    endtask

    // mostly well-formed commands, biased toward growing or shrinking the list
    task automatic send_random_command(input bit grow);
        int unsigned       sz;
        int unsigned       r;
        logic [FUNC_W-1:0] f;
        logic [POS_W-1:0]  p;
        sz = list_shadow.size();
        r  = $urandom_range(0, 99);
        if (r < 3)
            f = FN_UNUSED_6;
        else if (r < 6)
            f = FN_UNUSED_7;
        else if (r < (grow ? 70 : 30))
        begin
            case ($urandom_range(0, 2))
                0:       f = FN_ADD_FRONT;
                1:       f = FN_ADD_BACK;
                default: f = FN_INSERT;
            endcase
        end
        else
        begin
            case ($urandom_range(0, 2))
                0:       f = FN_DEL_FRONT;
                1:       f = FN_DEL_BACK;
                default: f = FN_DEL_POS;
            endcase
        end
        if ($urandom_range(0, 7) == 0)
            p = POS_W'($urandom);
        else if (f == FN_INSERT)
            p = POS_W'($urandom_range(1, sz + 1));
        else
            p = POS_W'($urandom_range(1, (sz == 0) ? 1 : sz));
        send_command(f, p, $urandom);
    endtask

    task automatic test_empty_list();
        send_command(FN_DEL_FRONT, 5'd0, $urandom);
        send_command(FN_DEL_BACK, 5'd31, $urandom);
        send_command(FN_DEL_POS, 5'd1, $urandom);
        send_command(FN_INSERT, 5'd0, 32'h0000_0000);
        send_command(FN_INSERT, 5'd31, 32'hFFFF_FFFF);
        send_command(FN_UNUSED_6, 5'd1, $urandom);
        send_command(FN_UNUSED_7, 5'd31, $urandom);
    endtask

    task automatic test_edges_and_positions();
        send_command(FN_INSERT, 5'd1, 32'h8000_0000);
        send_command(FN_ADD_FRONT, 5'd0, 32'h7FFF_FFFF);
        send_command(FN_ADD_BACK, 5'd31, 32'h0000_0000);
        send_command(FN_ADD_BACK, 5'd0, 32'hFFFF_FFFF);
        send_command(FN_INSERT, 5'd5, 32'h0000_04D2);
        send_command(FN_INSERT, 5'd3, $urandom);
        send_command(FN_INSERT, 5'd8, $urandom);
        send_command(FN_DEL_POS, 5'd7, $urandom);
        send_command(FN_DEL_POS, 5'd0, $urandom);
        send_command(FN_DEL_POS, 5'd3, $urandom);
        send_command(FN_DEL_FRONT, 5'd31, $urandom);
        send_command(FN_DEL_BACK, 5'd0, $urandom);
        while (list_shadow.size() > 1)
            send_command(FN_DEL_BACK, 5'd0, $urandom);
        // removing the only element empties the list
        send_command(FN_DEL_POS, 5'd1, $urandom);
    endtask

    task automatic test_full_list();
        while (list_shadow.size() < CAPACITY)
            send_random_command(1'b1);
        send_command(FN_ADD_FRONT, 5'd0, $urandom);
        send_command(FN_ADD_BACK, 5'd31, $urandom);
        send_command(FN_INSERT, 5'd31, $urandom);
        send_command(FN_INSERT, 5'd0, $urandom);
        send_command(FN_DEL_POS, 5'd31, $urandom);
        send_command(FN_DEL_POS, 5'd16, $urandom);
        send_command(FN_ADD_BACK, 5'd0, $urandom);
        send_command(FN_DEL_FRONT, 5'd0, $urandom);
    endtask

    task automatic test_backpressure();
        steady_flow        = 1'b1;
        result_hold_cycles = 300;
        repeat (24)
            send_random_command(1'b1);
        steady_flow = 1'b0;
    endtask

    task automatic test_random_mix(input int unsigned n_items);
        bit grow;
        grow = 1'b1;
        for (int i = 0; i < n_items; i++)
        begin
            if (i % 50 == 0)
                grow = ~grow;
            if (i % 30 == 0)
                steady_flow = ($urandom_range(0, 3) == 0);
            send_random_command(grow);
        end
        steady_flow = 1'b0;
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        cmd_bus.valid    <= 1'b0;
        cmd_bus.func     <= '0;
        cmd_bus.position <= '0;
        cmd_bus.value    <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_list();
        test_edges_and_positions();
        test_full_list();
        test_backpressure();
        test_random_mix(330);

        cmd_bus.valid <= 1'b0;
        while (expected_views.size() != 0)
            @(posedge clk);
        repeat (2 * CAPACITY) @(posedge clk);
        if (mismatch_count == 0)
            $display("** positional_list_engine: PASSED **");
        else
            $display("** positional_list_engine: FAILED **");
        $finish;
    end

    // result side flow control, including the long hold
    initial
    begin
        int unsigned stall;
        res_bus.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            stall = idle_cycles();
            if (stall != 0 || result_hold_cycles != 0)
            begin
                res_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
                if (result_hold_cycles != 0)
                begin
                    repeat (result_hold_cycles) @(posedge clk);
                    result_hold_cycles = 0;
                end
            end
            res_bus.ready <= 1'b1;
            @(posedge clk);
            while (res_bus.valid !== 1'b1)
                @(posedge clk);
        end
    end

    function automatic void compare_field(input string       field,
                                          input logic [31:0] want,
                                          input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, actual 0x%0h", field, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        list_view_t want;
        if (rst_n === 1'b1 && res_bus.valid === 1'b1 && res_bus.ready === 1'b1)
        begin
            if (expected_views.size() == 0)
            begin
                $error("result transaction with nothing expected");
                mismatch_count++;
            end
            else
            begin
                want = expected_views.pop_front();
                compare_field("status", 32'(want.status), 32'(res_bus.status));
                compare_field("count", 32'(want.count), 32'(res_bus.count));
                compare_field("has_element", 32'(want.has_element),
                              32'(res_bus.has_element));
                compare_field("element_index", 32'(want.element_index),
                              32'(res_bus.element_index));
                compare_field("element_value", want.element_value, res_bus.element_value);
                compare_field("last", 32'(want.last), 32'(res_bus.last));
            end
        end
    end

endmodule
